@@ hw/rtl/ntbtx_pkg.sv @@
// shared types and constants for the ncm ntb16 transmit framer
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps
`default_nettype none

package ntbtx_pkg;

    // largest frame that is framed; longer frames are rejected
    localparam int MAX_FRAME = 1514;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ATTACHED    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SIZE_LOG2 = 1'd1;
    localparam logic [3:0]           PKT_LOG2_RESET       = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_LINK  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // back sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_PAD,
        BK_TRAIL
    } t_bk_state;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] frame_length;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_block;
        logic       zero_packet_needed;
        logic [1:0] status;
    } t_out;

    // one classified request
    typedef struct packed {
        logic        err;
        logic [1:0]  status;
        logic        hdr;
        logic        last;
        logic [7:0]  data_byte;
        logic [11:0] frame_length;
        logic [15:0] seq;
    } t_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/ncm_ntb16_tx_framer.sv @@
// a result passes through the command queue into the output register
// throughput: one result per cycle while the receiver is ready; data bytes enter one
// per cycle while the queue has room; a good frame adds 12 header bytes and 16 to 19
// pad and trailer bytes, an error one byte; output rate is set by the back sequencer
// reset (synchronous, active low) clears frame tracking, sequence and queue
`timescale 1ns / 1ps
`default_nettype none

// top level: configuration registers, front classifier, command queue and
// back sequencer; uses ntbtx_pkg, ntbtx_front, ntbtx_fifo, ntbtx_back

module ncm_ntb16_tx_framer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // frame bytes in
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  ntbtx_pkg::t_in                      i_in,
    // block bytes out
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output ntbtx_pkg::t_out                     o_out,
    // configuration writes
    input  wire                                 i_cfg_we,
    input  wire  [ntbtx_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [ntbtx_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // configuration registers
    logic       r_link_attached;
    logic [3:0] r_pkt_log2;

    // queue signals between front and back
    logic            push;
    logic            pop;
    logic            fifo_full;
    logic            fifo_valid;
    ntbtx_pkg::t_cmd cmd;
    ntbtx_pkg::t_cmd head;

    // config writes are registered, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_attached <= 1'b0;
            r_pkt_log2      <= ntbtx_pkg::PKT_LOG2_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ntbtx_pkg::CFG_LINK_ATTACHED:    r_link_attached <= i_cfg_data[0];
                ntbtx_pkg::CFG_PACKET_SIZE_LOG2: r_pkt_log2      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: frame position, drop state, sequence number; one request per kept byte or rejected frame
    ntbtx_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in            (i_in),
        .i_link_attached (r_link_attached),
        .i_fifo_full     (fifo_full),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    // short queue so input and output stall independently
    ntbtx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_head  (head)
    );

    // back: header, data, pad, trailer and error bytes into the output register
    ntbtx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (fifo_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_pkt_log2   (r_pkt_log2),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

@@ hw/rtl/ntbtx_front.sv @@
// front part: accepts frame bytes, tracks frame position and drop state,
// and turns each kept byte or rejected frame into a command for the queue; uses ntbtx_pkg
`timescale 1ns / 1ps
`default_nettype none

module ntbtx_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  ntbtx_pkg::t_in    i_in,
    input  wire               i_link_attached,
    input  wire               i_fifo_full,
    output logic              o_push,
    output ntbtx_pkg::t_cmd   o_cmd
);

    logic [11:0] r_bytes_seen, n_bytes_seen;
    logic        r_dropping, n_dropping;
    logic [15:0] r_seq, n_seq;

    logic [11:0] len_n;
    logic [11:0] inc;
    logic        first;
    logic        last;
    logic        accept;
    logic [1:0]  st;

    assign o_in_ready = !i_fifo_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        len_n = (i_in.frame_length == 12'd0) ? 12'd1 : i_in.frame_length;
        first = (r_bytes_seen == 12'd0) && !r_dropping;
        inc   = r_bytes_seen + 12'd1;
        last  = (inc >= len_n) || (inc == 12'd0);
        if (!i_link_attached) begin
            st = ntbtx_pkg::ST_NO_LINK;
        end else if (len_n > 12'(ntbtx_pkg::MAX_FRAME)) begin
            st = ntbtx_pkg::ST_TOO_LONG;
        end else begin
            st = ntbtx_pkg::ST_OK;
        end

        n_bytes_seen       = r_bytes_seen;
        n_dropping         = r_dropping;
        n_seq              = r_seq;
        o_push             = 1'b0;
        o_cmd.err          = 1'b0;
        o_cmd.status       = st;
        o_cmd.hdr          = (inc == 12'd1);
        o_cmd.last         = last;
        o_cmd.data_byte    = i_in.data_byte;
        o_cmd.frame_length = len_n;
        o_cmd.seq          = r_seq;

        if (accept) begin
            if (first && st != ntbtx_pkg::ST_OK) begin
                // rejected frame: one error request, drop the rest
                o_push       = 1'b1;
                o_cmd.err    = 1'b1;
                n_dropping   = (len_n > 12'd1);
                n_bytes_seen = (len_n > 12'd1) ? 12'd1 : 12'd0;
            end else if (r_dropping) begin
                n_bytes_seen = last ? 12'd0 : inc;
                n_dropping   = !last;
            end else begin
                o_push       = 1'b1;
                n_bytes_seen = last ? 12'd0 : inc;
                if (inc == 12'd1) begin
                    n_seq = r_seq + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= 12'd0;
            r_dropping   <= 1'b0;
            r_seq        <= 16'd0;
        end else begin
            r_bytes_seen <= n_bytes_seen;
            r_dropping   <= n_dropping;
            r_seq        <= n_seq;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ntbtx_fifo.sv @@
// short command queue between front and back, first word fall through
// uses ntbtx_pkg for the command type and depth
`timescale 1ns / 1ps
`default_nettype none

module ntbtx_fifo (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  ntbtx_pkg::t_cmd   i_cmd,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_valid,
    output ntbtx_pkg::t_cmd   o_head
);

    ntbtx_pkg::t_cmd r_mem [ntbtx_pkg::FIFO_DEPTH];

    logic [ntbtx_pkg::FIFO_AW-1:0] r_wr, r_rd;
    logic [ntbtx_pkg::FIFO_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == ntbtx_pkg::FIFO_CW'(ntbtx_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ntbtx_back.sv @@
// back part: expands queued requests into nth16 header, data, padding and
// ndp16 trailer bytes, or one error byte, into an output register; uses ntbtx_pkg
`timescale 1ns / 1ps
`default_nettype none

module ntbtx_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_fifo_valid,
    input  ntbtx_pkg::t_cmd   i_head,
    output logic              o_pop,
    input  wire  [3:0]        i_pkt_log2,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output ntbtx_pkg::t_out   o_out
);

    localparam logic [3:0] HDR_LAST = 4'd11;
    localparam logic [3:0] TRL_LAST = 4'd15;

    ntbtx_pkg::t_bk_state r_state, n_state;
    logic [3:0]      r_idx, n_idx;
    logic            r_hdr_done, n_hdr_done;
    logic [11:0]     r_len, n_len;
    logic            r_out_valid;
    ntbtx_pkg::t_out r_out;

    logic            cand_valid;
    ntbtx_pkg::t_out cand;
    logic            fire;
    logic [1:0]      pad;
    logic [12:0]     trl_total;
    logic [15:0]     mask;

    // ndp offset: (12 + len + 3) rounded down to a multiple of 4
    function automatic logic [12:0] ndp_off(input logic [11:0] len);
        ndp_off = (13'(len) + 13'd15) & 13'h1FFC;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx,
                                            input logic [15:0] seq,
                                            input logic [11:0] len);
        logic [12:0] off;
        logic [12:0] tot;
        off = ndp_off(len);
        tot = off + 13'd16;
        case (idx)
            4'd0:    hdr_byte = 8'h4E;
            4'd1:    hdr_byte = 8'h43;
            4'd2:    hdr_byte = 8'h4D;
            4'd3:    hdr_byte = 8'h48;
            4'd4:    hdr_byte = 8'h0C;
            4'd6:    hdr_byte = seq[7:0];
            4'd7:    hdr_byte = seq[15:8];
            4'd8:    hdr_byte = tot[7:0];
            4'd9:    hdr_byte = {3'd0, tot[12:8]};
            4'd10:   hdr_byte = off[7:0];
            4'd11:   hdr_byte = {3'd0, off[12:8]};
            default: hdr_byte = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] trl_byte(input logic [3:0] idx,
                                            input logic [11:0] len);
        case (idx)
            4'd0:    trl_byte = 8'h4E;
            4'd1:    trl_byte = 8'h43;
            4'd2:    trl_byte = 8'h4D;
            4'd3:    trl_byte = 8'h30;
            4'd4:    trl_byte = 8'h10;
            4'd8:    trl_byte = 8'h0C;
            4'd10:   trl_byte = len[7:0];
            4'd11:   trl_byte = {4'd0, len[11:8]};
            default: trl_byte = 8'h00;
        endcase
    endfunction

    assign fire = cand_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        pad       = 2'd0 - i_head.frame_length[1:0];
        trl_total = ndp_off(r_len) + 13'd16;
        mask      = (16'd1 << i_pkt_log2) - 16'd1;

        n_state    = r_state;
        n_idx      = r_idx;
        n_hdr_done = r_hdr_done;
        n_len      = r_len;
        o_pop      = 1'b0;
        cand_valid = 1'b0;
        cand       = '0;

        case (r_state)
            ntbtx_pkg::BK_IDLE: begin
                if (i_fifo_valid) begin
                    cand_valid = 1'b1;
                    if (i_head.err) begin
                        cand.end_of_block = 1'b1;
                        cand.status       = i_head.status;
                        o_pop             = fire;
                    end else if (i_head.hdr && !r_hdr_done) begin
                        cand.out_byte = hdr_byte(4'd0, i_head.seq, i_head.frame_length);
                        if (fire) begin
                            n_state = ntbtx_pkg::BK_HEAD;
                            n_idx   = 4'd1;
                        end
                    end else begin
                        cand.out_byte = i_head.data_byte;
                        if (fire) begin
                            o_pop      = 1'b1;
                            n_hdr_done = 1'b0;
                            if (i_head.last) begin
                                n_len = i_head.frame_length;
                                if (pad != 2'd0) begin
                                    n_state = ntbtx_pkg::BK_PAD;
                                    n_idx   = {2'd0, pad};
                                end else begin
                                    n_state = ntbtx_pkg::BK_TRAIL;
                                    n_idx   = 4'd0;
                                end
                            end
                        end
                    end
                end
            end
            ntbtx_pkg::BK_HEAD: begin
                cand_valid    = 1'b1;
                cand.out_byte = hdr_byte(r_idx, i_head.seq, i_head.frame_length);
                if (fire) begin
                    if (r_idx == HDR_LAST) begin
                        n_state    = ntbtx_pkg::BK_IDLE;
                        n_hdr_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            ntbtx_pkg::BK_PAD: begin
                cand_valid = 1'b1;
                if (fire) begin
                    if (r_idx == 4'd1) begin
                        n_state = ntbtx_pkg::BK_TRAIL;
                        n_idx   = 4'd0;
                    end else begin
                        n_idx = r_idx - 4'd1;
                    end
                end
            end
            ntbtx_pkg::BK_TRAIL: begin
                cand_valid    = 1'b1;
                cand.out_byte = trl_byte(r_idx, r_len);
                if (r_idx == TRL_LAST) begin
                    cand.end_of_block       = 1'b1;
                    cand.zero_packet_needed = ((16'(trl_total) & mask) == 16'd0);
                end
                if (fire) begin
                    if (r_idx == TRL_LAST) begin
                        n_state = ntbtx_pkg::BK_IDLE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = ntbtx_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ntbtx_pkg::BK_IDLE;
            r_idx       <= 4'd0;
            r_hdr_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_hdr_done <= n_hdr_done;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        if (fire) begin
            r_out <= cand;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // header bytes come from the queue head, which must still be there
    a_head_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntbtx_pkg::BK_HEAD) |-> i_fifo_valid)
        else $error("header in progress without queued request");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_fifo_valid && fire))
        else $error("queue popped without a request taken");

    a_zlp_eob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.zero_packet_needed) |->
            (r_out.end_of_block && r_out.status == ntbtx_pkg::ST_OK))
        else $error("zero packet flag off the end of a good block");

    a_trail_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntbtx_pkg::BK_TRAIL && r_idx == TRL_LAST && fire) |=>
            (r_state == ntbtx_pkg::BK_IDLE))
        else $error("trailer did not end the block");

endmodule

`default_nettype wire

@@ test/tb_ncm_ntb16_tx_framer.sv @@
// self-checking testbench for the ncm ntb16 transmit framer
// drives frame bytes, config writes and output stalls; predicts every block byte
// depends on ntbtx_pkg and ncm_ntb16_tx_framer only
`timescale 1ns / 1ps

module tb_ncm_ntb16_tx_framer;

    import ntbtx_pkg::*;

    // block layout constants
    localparam logic [31:0] NTH_SIGNATURE = 32'h484D_434E;   // "NCMH"
    localparam logic [31:0] NDP_SIGNATURE = 32'h304D_434E;   // "NCM0"
    localparam int          NTH_BYTES     = 12;
    localparam int          NDP_BYTES     = 16;
    // cycles allowed after the last result for a dropped byte still in flight
    localparam int          SETTLE_CYCLES = 8;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in              in_pl;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out             out_pl;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the block state and registers
    logic [11:0]      frame_pos;
    bit               discarding;
    logic [15:0]      ntb_seq;
    bit               link_up;
    logic [3:0]       zlp_log2;

    // block bytes still owed by the dut, oldest first
    t_out             ntb_expect_q[$];
    t_out             want;
    int               errors;

    // idling controls
    bit               calm;        // no input gaps while set; receiver ready too unless a hold-off runs
    int               hold_off;    // receiver hold-off, counted down by the ready process
    int               ready_gap;

    ncm_ntb16_tx_framer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_pl),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_pl),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 6);
        return $urandom_range(15, 60);
    endfunction

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void owe_byte(input logic [7:0] b, input logic eob, input logic zlp,
                                     input logic [1:0] st);
        t_out e;
        e.out_byte           = b;
        e.end_of_block       = eob;
        e.zero_packet_needed = zlp;
        e.status             = st;
        ntb_expect_q.push_back(e);
    endfunction

    // little-endian 16-bit field
    function automatic void owe_le16(input logic [15:0] v);
        owe_byte(v[7:0], 1'b0, 1'b0, ST_OK);
        owe_byte(v[15:8], 1'b0, 1'b0, ST_OK);
    endfunction

    function automatic void owe_le32(input logic [31:0] v);
        owe_le16(v[15:0]);
        owe_le16(v[31:16]);
    endfunction

    // block bytes caused by one accepted frame byte
    function automatic void predict_ntb_bytes(input logic [7:0] b, input logic [11:0] len_in);
        logic [11:0] len;
        logic [1:0]  st;
        bit          at_end;
        int unsigned ndp_off;
        int unsigned blk_len;
        int unsigned pad;
        int unsigned mask;
        len = (len_in == 12'd0) ? 12'd1 : len_in;

        // admission checks on the first byte of a frame only
        if (frame_pos == 12'd0 && !discarding) begin
            st = ST_OK;
            if (!link_up)
                st = ST_NO_LINK;
            else if (len > MAX_FRAME)
                st = ST_TOO_LONG;
            if (st != ST_OK) begin
                owe_byte(8'd0, 1'b1, 1'b0, st);
                frame_pos  = 12'd1;
                discarding = 1'b1;
                if (frame_pos >= len) begin
                    frame_pos  = 12'd0;
                    discarding = 1'b0;
                end
                return;
            end
        end

        frame_pos = frame_pos + 12'd1;
        at_end    = (frame_pos >= len) || (frame_pos == 12'd0);

        // rest of a rejected frame is swallowed
        if (discarding) begin
            if (at_end) begin
                frame_pos  = 12'd0;
                discarding = 1'b0;
            end
            return;
        end

        ndp_off = (NTH_BYTES + len + 3) & ~32'd3;
        blk_len = ndp_off + NDP_BYTES;

        // nth16 ahead of the first byte
        if (frame_pos == 12'd1) begin
            owe_le32(NTH_SIGNATURE);
            owe_le16(16'(NTH_BYTES));
            owe_le16(ntb_seq);
            owe_le16(blk_len[15:0]);
            owe_le16(ndp_off[15:0]);
            ntb_seq = ntb_seq + 16'd1;
        end

        owe_byte(b, 1'b0, 1'b0, ST_OK);

        // padding, ndp16 and the terminator entry
        if (at_end) begin
            pad = ndp_off - NTH_BYTES - len;
            for (int unsigned k = 0; k < pad && k < 3; k++)
                owe_byte(8'd0, 1'b0, 1'b0, ST_OK);
            owe_le32(NDP_SIGNATURE);
            owe_le16(16'(NDP_BYTES));
            owe_le16(16'd0);
            owe_le16(16'(NTH_BYTES));
            owe_le16({4'd0, len});
            owe_le16(16'd0);
            owe_byte(8'd0, 1'b0, 1'b0, ST_OK);
            mask = (32'd1 << zlp_log2) - 32'd1;
            owe_byte(8'd0, 1'b1, (blk_len & mask) == 0, ST_OK);
            frame_pos = 12'd0;
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers, all entered and left at a falling edge
    // ---------------------------------------------------------------

    // one frame byte; valid stays high on return so back-to-back requests need no dip
    task automatic send_byte(input logic [7:0] b, input logic [11:0] len);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_pl    <= '{data_byte: b, frame_length: len};
        do @(posedge clk); while (!in_ready);
        predict_ntb_bytes(b, len);
        @(negedge clk);
    endtask

    // a frame of random bytes; a wobbly one gets an odd frame length now and then
    task automatic send_frame(input int len, input bit wobble, output int sent);
        logic [11:0] flen;
        sent = 0;
        for (int i = 0; i < len; i++) begin
            flen = 12'(len);
            if (wobble && $urandom_range(0, 7) == 0)
                flen = 12'($urandom_range(0, 4095));
            send_byte(8'($urandom_range(0, 255)), flen);
            sent++;
        end
    endtask

    // oversized first byte, then a short length so the drop ends on the next byte
    task automatic send_too_long();
        send_byte(8'($urandom_range(0, 255)), 12'($urandom_range(MAX_FRAME + 1, 4095)));
        send_byte(8'($urandom_range(0, 255)), 12'($urandom_range(0, 2)));
    endtask

    // sender pauses until every owed byte is out and any dropped byte has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (ntb_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // register write, only called while the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
        if (idx == CFG_LINK_ATTACHED)
            link_up = d[0];
        else if (idx == CFG_PACKET_SIZE_LOG2)
            zlp_log2 = d;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // link is detached out of reset: every frame gives one error request
    task automatic test_detached_reject();
        int n;
        send_frame(3, 1'b0, n);
        send_byte(8'hFF, 12'd0);            // zero length counts as one byte
        send_byte(8'h00, 12'd4095);         // longest length, cut short below
        send_byte(8'h81, 12'd1);
        wait_drained();
    endtask

    // frame shapes with a packet size of 8 bytes
    task automatic test_frame_shapes();
        int n;
        cfg_write(CFG_LINK_ATTACHED, 4'b1111);
        cfg_write(CFG_PACKET_SIZE_LOG2, 4'd3);
        send_byte(8'h00, 12'd1);            // one byte, three pad bytes
        send_byte(8'hFF, 12'd0);            // zero length treated as one
        send_frame(4, 1'b0, n);             // no padding, block of 32
        send_frame(6, 1'b0, n);             // two pad bytes
        send_frame(7, 1'b0, n);             // one pad byte
        send_too_long();
        // header sized for the largest good frame, then the length shrinks
        send_byte(8'hA5, 12'(MAX_FRAME));
        send_byte(8'h5A, 12'd2);
        // length grows mid-frame, then drops back
        send_byte(8'h3C, 12'd2);
        send_byte(8'hC3, 12'd4095);
        send_byte(8'h99, 12'd3);
        wait_drained();
    endtask

    // a frame already started is framed to its end after the link goes away
    task automatic test_link_drop_mid_frame();
        send_byte(8'h11, 12'd9);
        send_byte(8'h22, 12'd9);
        wait_drained();
        cfg_write(CFG_LINK_ATTACHED, 4'b1110);
        for (int i = 0; i < 7; i++)
            send_byte(8'($urandom_range(0, 255)), 12'd9);
        send_byte(8'h44, 12'd2);            // new frame, rejected
        send_byte(8'h55, 12'd2);
        wait_drained();
        cfg_write(CFG_LINK_ATTACHED, 4'b0001);
    endtask

    // zero packet flag across packet sizes, out-of-range ones too
    task automatic test_packet_sizes();
        logic [3:0] sizes [4];
        int         lens  [4];
        int         n;
        sizes = '{4'd0, 4'd15, 4'd6, 4'd4};
        lens  = '{9, 9, 36, 3};             // 36 fills a 64-byte block
        for (int i = 0; i < 4; i++) begin
            cfg_write(CFG_PACKET_SIZE_LOG2, sizes[i]);
            send_frame(lens[i], 1'b0, n);
            wait_drained();
        end
    endtask

    // receiver holds off while the sender keeps offering, then sender waits for all
    task automatic test_output_backpressure();
        int n;
        cfg_write(CFG_PACKET_SIZE_LOG2, 4'd6);
        calm     = 1'b1;
        hold_off = 300;
        send_frame(60, 1'b0, n);
        calm = 1'b0;
        wait_drained();
    endtask

    // phases of random settings and mostly well-formed frames
    task automatic test_random_traffic();
        int         counted;
        int         r;
        int         len;
        int         n;
        logic [3:0] d;
        counted = 0;
        while (counted < 120) begin
            r    = $urandom_range(0, 99);
            d    = 4'($urandom_range(0, 15));
            d[0] = (r < 85);
            cfg_write(CFG_LINK_ATTACHED, d);
            if ($urandom_range(0, 9) < 7)
                d = 4'($urandom_range(3, 6));
            else
                d = 4'($urandom_range(0, 15));
            cfg_write(CFG_PACKET_SIZE_LOG2, d);
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 5)) begin
                r = $urandom_range(0, 99);
                if (r < 90) begin
                    if (r < 75)
                        len = $urandom_range(1, 24);
                    else
                        len = $urandom_range(25, 90);
                    // a few frames get their length disturbed
                    send_frame(len, r >= 65 && r < 75, n);
                end else begin
                    send_too_long();
                    n = 2;
                end
                counted += n;
            end
            calm = 1'b0;
            wait_drained();
        end
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls, the long hold-off, or always ready
    // ---------------------------------------------------------------

    always @(negedge clk) begin
        if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off = hold_off - 1;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else if (ready_gap > 0) begin
            out_ready <= 1'b0;
            ready_gap = ready_gap - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_gap = pick_gap();
        end
    end

    // ---------------------------------------------------------------
    // checker: each accepted block byte against the oldest owed one
    // ---------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (ntb_expect_q.size() == 0) begin
                $error("block byte %0h with nothing owed", out_pl.out_byte);
                errors++;
            end else begin
                want = ntb_expect_q.pop_front();
                if (out_pl.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, out_pl.out_byte);
                    errors++;
                end
                if (out_pl.end_of_block !== want.end_of_block) begin
                    $error("end_of_block: expected %0b, got %0b",
                           want.end_of_block, out_pl.end_of_block);
                    errors++;
                end
                if (out_pl.zero_packet_needed !== want.zero_packet_needed) begin
                    $error("zero_packet_needed: expected %0b, got %0b",
                           want.zero_packet_needed, out_pl.zero_packet_needed);
                    errors++;
                end
                if (out_pl.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_pl.status);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_pl      = '0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_LINK_ATTACHED;
        cfg_data   = '0;
        calm       = 1'b0;
        hold_off   = 0;
        ready_gap  = 0;
        errors     = 0;
        // predictor starts from the reset state
        frame_pos  = 12'd0;
        discarding = 1'b0;
        ntb_seq    = 16'd0;
        link_up    = 1'b0;
        zlp_log2   = PKT_LOG2_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_detached_reject();
        test_frame_shapes();
        test_link_drop_mid_frame();
        test_packet_sizes();
        test_output_backpressure();
        test_random_traffic();

        // final drain plus a tail for stray results
        wait_drained();
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
